>>> design/ate_pkg.sv
`default_nettype none

package ate_pkg;

    // screen geometry and sequence limit
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int SEQ_MAX = 40;

    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int ADDR_W  = 11;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CLR_W   = 4;
    localparam int SEQ_W   = 6;
    localparam int ACC_W   = 10;
    localparam int PCNT_W  = 6;

    localparam logic [ACC_W-1:0]  ACCUM_MAX = '1;
    localparam logic [PCNT_W-1:0] COUNT_MAX = '1;

    // byte codes
    localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ESC    = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_J      = 8'h4A;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_G      = 8'h67;
    localparam logic [CHAR_W-1:0] CH_M      = 8'h6D;

    localparam logic [CLR_W-1:0] DEFAULT_FORE = 4'h7;
    localparam logic [ACC_W-1:0] FORE_LO = 10'd30;
    localparam logic [ACC_W-1:0] FORE_HI = 10'd37;
    localparam logic [ACC_W-1:0] BACK_LO = 10'd40;
    localparam logic [ACC_W-1:0] BACK_HI = 10'd47;
    localparam logic [ACC_W-1:0] SGR_RESET  = 10'd0;
    localparam logic [ACC_W-1:0] SGR_BRIGHT = 10'd1;
    localparam logic [ACC_W-1:0] ERASE_ALL  = 10'd2;

    // ansi color order to display palette order
    localparam logic [CLR_W-1:0] COLOUR_MAP [16] = '{
        4'd0, 4'd4, 4'd2, 4'd6, 4'd1, 4'd5, 4'd3, 4'd7,
        4'd8, 4'd12, 4'd10, 4'd14, 4'd9, 4'd13, 4'd11, 4'd15
    };

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_SCROLL = 2'd2,
        KIND_CURSOR = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [ADDR_W-1:0]  addr;
        logic [CHAR_W-1:0]  glyph;
        logic [ATTR_W-1:0]  attr;
        logic               last;
    } cmd_t;

    // up to three commands produced by one byte, slot 0 first
    typedef struct packed {
        cmd_t [2:0]  cmd;
        logic [1:0]  count;
    } batch_t;

    typedef struct packed {
        logic [CLR_W-1:0] fore;
        logic [CLR_W-1:0] back;
        logic             bright;
    } colours_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
        return ADDR_W'(int'(row) * COLUMNS + int'(col));
    endfunction

    // one sgr parameter applied to the pending colors
    function automatic colours_t apply_param(input colours_t p, input logic [ACC_W-1:0] v);
        colours_t         r;
        logic [ACC_W-1:0] fd;
        logic [ACC_W-1:0] bd;
        r  = p;
        fd = v - FORE_LO;
        bd = v - BACK_LO;
        if (v == SGR_RESET)
        begin
            r.bright = 1'b0;
        end
        else if (v == SGR_BRIGHT)
        begin
            r.bright = 1'b1;
        end
        else if (v >= FORE_LO && v <= FORE_HI)
        begin
            r.fore = COLOUR_MAP[{p.bright, fd[2:0]}];
        end
        else if (v >= BACK_LO && v <= BACK_HI)
        begin
            r.back = COLOUR_MAP[{p.bright, bd[2:0]}];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/ansi_text_console_engine.sv
// channel   direction   handshake             payload
// in        input       in_valid / in_ready   char_code
// out       output      out_valid / out_ready kind, cell_address, glyph, attribute, last
//
// a byte is latched in the input register, decoded combinationally and its 0 to 3
// commands land in the command queue; they leave one per cycle while out_ready is high
// while out_ready is high, a byte is accepted every cycle as long as each byte yields
// at most one command; a byte with n commands (up to 3) holds the queue until all leave
// the queue reloads in the same cycle its last command is taken
// rst_n clears cursor, colors, escape state and all valid flags
// out_ready low stalls the queue, then the input register, then in_ready
`default_nettype none

module ansi_text_console_engine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [ate_pkg::CHAR_W-1:0]    char_code,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         kind,
    output logic [ate_pkg::ADDR_W-1:0]         cell_address,
    output logic [ate_pkg::CHAR_W-1:0]         glyph,
    output logic [ate_pkg::ATTR_W-1:0]         attribute,
    output logic                               last
);
    import ate_pkg::*;

    // input register
    logic                hold_valid_reg;
    logic [CHAR_W-1:0]   hold_char_reg;

    logic    fire;
    logic    pop;
    logic    can_load;
    batch_t  batch;
    cmd_t    head;

    // a byte is decoded once the queue can take its commands
    assign pop      = out_valid && out_ready;
    assign fire     = hold_valid_reg && can_load;
    assign in_ready = !hold_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_char_reg <= char_code;
        end
    end

    // escape parser, cursor and color state
    ate_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .char_code (hold_char_reg),
        .batch     (batch)
    );

    // result registers, drained one command per transaction
    ate_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .batch      (batch),
        .pop        (pop),
        .can_load   (can_load),
        .head_valid (out_valid),
        .head       (head)
    );

    assign kind         = head.kind;
    assign cell_address = head.addr;
    assign glyph        = head.glyph;
    assign attribute    = head.attr;
    assign last         = head.last;

endmodule

`default_nettype wire

>>> design/ate_parser.sv
`default_nettype none

module ate_parser (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      fire,
    input  wire logic [7:0]                char_code,
    output ate_pkg::batch_t                batch
);
    import ate_pkg::*;

    typedef enum logic [1:0] {
        PHASE_TEXT = 2'd0,
        PHASE_ESC  = 2'd1,
        PHASE_CSI  = 2'd2
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    colours_t            cur_reg, cur_next;
    colours_t            pend_reg, pend_next;
    logic [ACC_W-1:0]    accum_reg, accum_next;
    logic [SEQ_W-1:0]    seq_reg, seq_next;
    logic [PCNT_W-1:0]   pcnt_reg, pcnt_next;

    logic [ATTR_W-1:0]   cur_attr;
    logic [COL_W:0]      tx;
    logic [ROW_W:0]      ty;
    logic                t_write;
    logic [COL_W-1:0]    t_wcol;
    logic [CHAR_W-1:0]   t_glyph;
    logic                t_scroll;
    logic [1:0]          t_n;
    batch_t              text_batch;
    logic                text_path;
    logic [13:0]         digit_sum;

    assign cur_attr = {cur_reg.back, cur_reg.fore};

    // printable and control byte handling
    always_comb
    begin
        tx       = {1'b0, col_reg};
        ty       = {1'b0, row_reg};
        t_write  = 1'b0;
        t_wcol   = col_reg;
        t_glyph  = CH_SPACE;
        t_scroll = 1'b0;
        t_n      = 2'd0;
        text_batch = '0;
        unique case (char_code)
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    tx      = tx - 1'b1;
                    t_write = 1'b1;
                    t_wcol  = col_reg - 1'b1;
                end
            end
            CH_LF:
            begin
                tx = '0;
                ty = ty + 1'b1;
            end
            CH_TAB:
            begin
                tx = tx + (COL_W+1)'(8);
            end
            CH_CR:
            begin
            end
            default:
            begin
                t_write = 1'b1;
                t_glyph = char_code;
                tx      = tx + 1'b1;
            end
        endcase
        if (tx >= (COL_W+1)'(COLUMNS))
        begin
            tx = tx - (COL_W+1)'(COLUMNS);
            ty = ty + 1'b1;
        end
        if (ty >= (ROW_W+1)'(ROWS))
        begin
            ty       = (ROW_W+1)'(ROWS - 1);
            t_scroll = 1'b1;
        end
        if (t_write)
        begin
            text_batch.cmd[t_n] = '{KIND_WRITE, cell_addr(row_reg, t_wcol), t_glyph,
                                    cur_attr, 1'b0};
            t_n = t_n + 1'b1;
        end
        if (t_scroll)
        begin
            text_batch.cmd[t_n] = '{KIND_SCROLL, '0, CH_SPACE, cur_attr, 1'b0};
            t_n = t_n + 1'b1;
        end
        text_batch.cmd[t_n] = '{KIND_CURSOR, cell_addr(ty[ROW_W-1:0], tx[COL_W-1:0]),
                                '0, '0, 1'b1};
        text_batch.count = t_n + 1'b1;
    end

    assign digit_sum = 14'(accum_reg) * 14'd10 + 14'(char_code[3:0]);

    always_comb
    begin
        phase_next = phase_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        cur_next   = cur_reg;
        pend_next  = pend_reg;
        accum_next = accum_reg;
        seq_next   = seq_reg;
        pcnt_next  = pcnt_reg;
        text_path  = 1'b0;
        batch      = '0;
        unique case (phase_reg)
            PHASE_CSI:
            begin
                priority if (char_code == CH_M)
                begin
                    if (seq_reg != '0)
                    begin
                        cur_next = apply_param(pend_reg, accum_reg);
                    end
                    else
                    begin
                        cur_next = pend_reg;
                    end
                    phase_next = PHASE_TEXT;
                end
                else if (char_code == CH_J)
                begin
                    phase_next = PHASE_TEXT;
                    if (seq_reg == SEQ_W'(1) && accum_reg == ERASE_ALL && pcnt_reg == '0)
                    begin
                        batch.cmd[0] = '{KIND_CLEAR, '0, CH_SPACE, cur_attr, 1'b0};
                        batch.cmd[1] = '{KIND_CURSOR, '0, '0, '0, 1'b1};
                        batch.count  = 2'd2;
                        col_next     = '0;
                        row_next     = '0;
                    end
                end
                else if (char_code == CH_G)
                begin
                    phase_next = PHASE_TEXT;
                end
                else if (seq_reg >= SEQ_W'(SEQ_MAX))
                begin
                end
                else
                begin
                    seq_next = seq_reg + 1'b1;
                    if (char_code >= CH_ZERO && char_code <= CH_NINE)
                    begin
                        accum_next = (digit_sum > 14'(ACCUM_MAX)) ? ACCUM_MAX
                                                                  : digit_sum[ACC_W-1:0];
                    end
                    else if (char_code == CH_SEMI)
                    begin
                        pend_next  = apply_param(pend_reg, accum_reg);
                        accum_next = '0;
                        if (pcnt_reg != COUNT_MAX)
                        begin
                            pcnt_next = pcnt_reg + 1'b1;
                        end
                    end
                end
            end
            PHASE_ESC:
            begin
                if (char_code == CH_LBRACK)
                begin
                    phase_next = PHASE_CSI;
                    accum_next = '0;
                    seq_next   = '0;
                    pcnt_next  = '0;
                    pend_next  = cur_reg;
                end
                else
                begin
                    phase_next = PHASE_TEXT;
                    text_path  = 1'b1;
                end
            end
            default:
            begin
                phase_next = PHASE_TEXT;
                if (char_code == CH_ESC)
                begin
                    phase_next = PHASE_ESC;
                end
                else
                begin
                    text_path = 1'b1;
                end
            end
        endcase
        if (text_path)
        begin
            batch    = text_batch;
            col_next = tx[COL_W-1:0];
            row_next = ty[ROW_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_TEXT;
            col_reg   <= '0;
            row_reg   <= '0;
            cur_reg   <= '{DEFAULT_FORE, '0, 1'b0};
            pend_reg  <= '{DEFAULT_FORE, '0, 1'b0};
            accum_reg <= '0;
            seq_reg   <= '0;
            pcnt_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            cur_reg   <= cur_next;
            pend_reg  <= pend_next;
            accum_reg <= accum_next;
            seq_reg   <= seq_next;
            pcnt_reg  <= pcnt_next;
        end
    end

endmodule

`default_nettype wire

>>> design/ate_cmd_queue.sv
`default_nettype none

module ate_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire ate_pkg::batch_t batch,
    input  wire logic           pop,
    output logic                can_load,
    output logic                head_valid,
    output ate_pkg::cmd_t       head
);
    import ate_pkg::*;

    cmd_t        slot_reg [3];
    logic [1:0]  count_reg;

    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[0];
    // empty now, or the only remaining command leaves this cycle
    assign can_load   = (count_reg == 2'd0) || (count_reg == 2'd1 && pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (load)
        begin
            count_reg <= batch.count;
        end
        else if (pop)
        begin
            count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg[0] <= batch.cmd[0];
            slot_reg[1] <= batch.cmd[1];
            slot_reg[2] <= batch.cmd[2];
        end
        else if (pop)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule

`default_nettype wire

>>> design/ate_checker.sv
`default_nettype none

module ate_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic [ate_pkg::CHAR_W-1:0]    char_code,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic [1:0]                    kind,
    input  wire logic [ate_pkg::ADDR_W-1:0]    cell_address,
    input  wire logic [ate_pkg::CHAR_W-1:0]    glyph,
    input  wire logic [ate_pkg::ATTR_W-1:0]    attribute,
    input  wire logic                          last
);
    import ate_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(cell_address)
            && $stable(glyph) && $stable(attribute) && $stable(last))
        else $error("result changed while stalled");

    // a stalled input holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(char_code))
        else $error("input changed while stalled");

    // the last flag is set exactly on cursor updates, which end any byte's commands
    a_last_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (kind == KIND_CURSOR)))
        else $error("last flag does not match cursor command");

    // fills carry a blank glyph at address zero
    a_fill_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_CLEAR || kind == KIND_SCROLL)
            |-> cell_address == '0 && glyph == CH_SPACE)
        else $error("malformed fill command");

    // cursor addresses stay on screen, cursor carries no glyph or attribute
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_CURSOR |-> int'(cell_address) < COLUMNS * ROWS
            && glyph == '0 && attribute == '0)
        else $error("cursor command out of range");

endmodule

bind ansi_text_console_engine ate_checker u_checker (.*);

`default_nettype wire
